[hdl/srrw_pkg.sv]
// types and constants shared by the selective-repeat receive window modules
// no dependencies
package srrw_pkg;

    localparam logic [7:0] TAG_DATA = 8'h00;
    localparam logic [7:0] TAG_OVER = 8'h08;
    localparam logic [7:0] TAG_END  = 8'h16;

    localparam logic [15:0] CKSUM_GOOD = 16'hffff;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_OVER    = 2'd2,
        KIND_END     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACT,
        ST_DUP,
        ST_RD,
        ST_DLV
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  emit;
        t_kind kind;
        logic  last;
        logic  mark;
        logic  rd;
        logic  deliver;
        logic  clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hdr_ok;
        logic tag_data;
        logic tag_over;
        logic tag_end;
        logic in_ack;
        logic in_rx;
        logic dup;
        logic at_base;
        logic dlv_last;
        logic out_free;
    } t_stat;

endpackage

[hdl/srrw_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module srrw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/srrw_ctrl.sv]
// controller state machine for the receive window
// depends on srrw_pkg
module srrw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  srrw_pkg::t_stat i_stat,
    output srrw_pkg::t_cmd  o_cmd
);
    import srrw_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.kind = KIND_ACK;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_ACT;
                end
            end
            ST_ACT: begin
                priority if (!i_stat.hdr_ok) begin
                    n_state = ST_IDLE;
                end else if (i_stat.tag_end) begin
                    if (i_stat.out_free) begin
                        cmd.emit  = 1'b1;
                        cmd.kind  = KIND_END;
                        cmd.last  = 1'b1;
                        cmd.clear = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end else if (i_stat.tag_over) begin
                    if (i_stat.out_free) begin
                        cmd.emit  = 1'b1;
                        cmd.kind  = KIND_OVER;
                        cmd.last  = 1'b1;
                        cmd.clear = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end else if (i_stat.tag_data && i_stat.in_ack) begin
                    if (i_stat.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.kind = KIND_ACK;
                        priority if (i_stat.in_rx && i_stat.dup) begin
                            cmd.last = 1'b0;
                            n_state  = ST_DUP;
                        end else if (i_stat.in_rx && i_stat.at_base) begin
                            cmd.mark = 1'b1;
                            cmd.last = 1'b0;
                            n_state  = ST_RD;
                        end else if (i_stat.in_rx) begin
                            cmd.mark = 1'b1;
                            cmd.last = 1'b1;
                            n_state  = ST_IDLE;
                        end else begin
                            cmd.last = 1'b1;
                            n_state  = ST_IDLE;
                        end
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DUP: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_ACK;
                    cmd.last = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_RD: begin
                cmd.rd  = 1'b1;
                n_state = ST_DLV;
            end
            ST_DLV: begin
                if (i_stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_DELIVER;
                    cmd.last    = i_stat.dlv_last;
                    cmd.deliver = 1'b1;
                    n_state     = i_stat.dlv_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd      = cmd;

endmodule

[hdl/srrw_dp.sv]
// datapath: header check, window compare, slot flags, size memory, output register
// depends on srrw_pkg and srrw_ram
module srrw_dp #(
    parameter int WINDOW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_hdr_word0,
    input  logic [15:0]     i_hdr_word1,
    input  logic [15:0]     i_hdr_word2,
    input  logic [15:0]     i_hdr_word3,
    input  logic [15:0]     i_hdr_word4,
    input  srrw_pkg::t_cmd  i_cmd,
    output srrw_pkg::t_stat o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_ack_number,
    output logic [15:0]     o_ack_checksum,
    output logic [15:0]     o_deliver_seq,
    output logic [15:0]     o_deliver_size,
    output logic [31:0]     o_total_length,
    output logic            o_last
);
    import srrw_pkg::*;

    localparam int SLOTS = 2 * WINDOW;
    localparam int IDXW  = $clog2(SLOTS);
    localparam int SW    = $clog2(WINDOW + 1);

    // latched header
    logic [15:0] r_w0, r_w1, r_w2, r_w3, r_w4;

    logic [SLOTS-1:0] r_rcv;
    logic [16:0]      r_base;
    logic [IDXW-1:0]  r_base_idx;
    logic [31:0]      r_delivered;
    logic [SW-1:0]    r_steps;

    logic        r_out_valid;
    t_kind       r_kind;
    logic [7:0]  r_ack_number;
    logic [15:0] r_ack_cksum;
    logic [15:0] r_dseq;
    logic [15:0] r_dsize;
    logic [31:0] r_total;
    logic        r_last;

    logic [18:0]     cks_sum;
    logic [16:0]     cks_f1;
    logic [15:0]     cks_f2;
    logic [7:0]      tag;
    logic [17:0]     seq18;
    logic [17:0]     base18;
    logic [17:0]     win18;
    logic [17:0]     diff;
    logic [IDXW:0]   idx_sum;
    logic [IDXW-1:0] idx;
    logic [IDXW-1:0] next_idx;
    logic [15:0]     rdata;
    logic [32:0]     dsum;
    t_stat           stat;

    // ones-complement sum, folded twice for end-around carry
    assign cks_sum = 19'(r_w0) + 19'(r_w1) + 19'(r_w2) + 19'(r_w3) + 19'(r_w4);
    assign cks_f1  = 17'(cks_sum[15:0]) + 17'(cks_sum[18:16]);
    assign cks_f2  = cks_f1[15:0] + 16'(cks_f1[16]);

    assign tag    = r_w1[7:0];
    assign seq18  = {2'b00, r_w2};
    assign base18 = {1'b0, r_base};
    assign win18  = 18'(WINDOW);
    assign diff   = seq18 - base18;

    // slot of an in-window seq: base slot plus offset, wrapped once
    assign idx_sum = {1'b0, r_base_idx} + {1'b0, diff[IDXW-1:0]};
    assign idx = (idx_sum >= (IDXW+1)'(SLOTS)) ? IDXW'(idx_sum - (IDXW+1)'(SLOTS))
                                               : idx_sum[IDXW-1:0];
    assign next_idx = (r_base_idx == IDXW'(SLOTS - 1)) ? '0 : r_base_idx + 1'b1;

    always_comb begin
        stat          = '0;
        stat.hdr_ok   = (cks_f2 == CKSUM_GOOD);
        stat.tag_data = (tag == TAG_DATA);
        stat.tag_over = (tag == TAG_OVER);
        stat.tag_end  = (tag == TAG_END);
        stat.in_ack   = (seq18 + win18 >= base18) && (seq18 < base18 + win18);
        stat.in_rx    = (seq18 >= base18) && (seq18 < base18 + win18);
        stat.dup      = r_rcv[idx];
        stat.at_base  = (seq18 == base18);
        stat.dlv_last = (r_steps == SW'(WINDOW - 1)) || !r_rcv[next_idx];
        stat.out_free = !r_out_valid || i_out_ready;
    end
    assign o_stat = stat;

    srrw_ram #(
        .WIDTH (16),
        .DEPTH (SLOTS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mark),
        .i_waddr (idx),
        .i_wdata (r_w0),
        .i_re    (i_cmd.rd),
        .i_raddr (r_base_idx),
        .o_rdata (rdata)
    );

    assign dsum = {1'b0, r_delivered} + 33'(rdata);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w0 <= i_hdr_word0;
            r_w1 <= i_hdr_word1;
            r_w2 <= i_hdr_word2;
            r_w3 <= i_hdr_word3;
            r_w4 <= i_hdr_word4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_rcv       <= '0;
            r_base      <= '0;
            r_base_idx  <= '0;
            r_delivered <= '0;
            r_steps     <= '0;
        end else begin
            if (i_cmd.mark) begin
                r_rcv[idx] <= 1'b1;
                r_steps    <= '0;
            end
            if (i_cmd.deliver) begin
                r_rcv[r_base_idx] <= 1'b0;
                r_delivered <= dsum[32] ? 32'hffff_ffff : dsum[31:0];
                r_base      <= r_base + 17'd1;
                r_base_idx  <= (r_base == 17'h1ffff) ? '0 : next_idx;
                r_steps     <= r_steps + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind       <= i_cmd.kind;
            r_last       <= i_cmd.last;
            r_ack_number <= (i_cmd.kind == KIND_ACK) ? r_w2[7:0] : 8'h00;
            r_ack_cksum  <= (i_cmd.kind == KIND_ACK) ? (16'hffff ^ {8'h00, r_w2[7:0]})
                                                     : 16'h0000;
            r_dseq       <= (i_cmd.kind == KIND_DELIVER) ? r_base[15:0] : 16'h0000;
            r_dsize      <= (i_cmd.kind == KIND_DELIVER) ? rdata : 16'h0000;
            r_total      <= (i_cmd.kind == KIND_OVER) ? r_delivered : 32'h0000_0000;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_ack_number   = r_ack_number;
    assign o_ack_checksum = r_ack_cksum;
    assign o_deliver_seq  = r_dseq;
    assign o_deliver_size = r_dsize;
    assign o_total_length = r_total;
    assign o_last         = r_last;

endmodule

[hdl/selective_repeat_receiver_window.sv]
// selective-repeat receive window: one header item in, up to WINDOW+1 result items out.
// Once an item is accepted the act state checks and acts on the header: a bad checksum,
// unknown tag or out-of-range data item ends there with no result; otherwise one result
// (ack, over or end) is written to the output register, a duplicate adds a second ack
// (dup state), and an in-order slide runs the read and deliver states per delivered
// slot (size memory read, then output). The input is ready again once the last result
// of the item is in the output register; a stalled output holds the controller.
// No clearing pass after reset. Depends on srrw_pkg, srrw_ctrl, srrw_dp, srrw_ram.
module selective_repeat_receiver_window #(
    parameter int WINDOW = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_hdr_word0,
    input  logic [15:0] i_hdr_word1,
    input  logic [15:0] i_hdr_word2,
    input  logic [15:0] i_hdr_word3,
    input  logic [15:0] i_hdr_word4,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_ack_number,
    output logic [15:0] o_ack_checksum,
    output logic [15:0] o_deliver_seq,
    output logic [15:0] o_deliver_size,
    output logic [31:0] o_total_length,
    output logic        o_last
);
    import srrw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    srrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srrw_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hdr_word0    (i_hdr_word0),
        .i_hdr_word1    (i_hdr_word1),
        .i_hdr_word2    (i_hdr_word2),
        .i_hdr_word3    (i_hdr_word3),
        .i_hdr_word4    (i_hdr_word4),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_ack_number   (o_ack_number),
        .o_ack_checksum (o_ack_checksum),
        .o_deliver_seq  (o_deliver_seq),
        .o_deliver_size (o_deliver_size),
        .o_total_length (o_total_length),
        .o_last         (o_last)
    );

endmodule

[test/tb_selective_repeat_receiver_window.sv]
// testbench for selective_repeat_receiver_window: random and directed header items,
// results checked against a scoreboard that tracks the receive window
// depends on srrw_pkg and the selective_repeat_receiver_window rtl
`timescale 1ns / 100ps

module tb_selective_repeat_receiver_window;
    import srrw_pkg::*;

    localparam int WINDOW     = 32;
    localparam int SLOTS      = 2 * WINDOW;
    localparam int ITEM_GOAL  = 350;
    localparam int HOLD_AT    = 120;
    localparam int HOLD_LEN   = 300;
    localparam int CYCLE_CAP  = 1000000;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ack_number;
        logic [15:0] ack_checksum;
        logic [15:0] deliver_seq;
        logic [15:0] deliver_size;
        logic [31:0] total_length;
        logic        last;
    } t_rx_result;

    class window_scoreboard;
        bit          received [SLOTS];
        logic [15:0] slot_bytes [SLOTS];
        int          base;
        logic [31:0] delivered;
        t_rx_result  pending_results [$];
        int          errors;

        function new();
            clear_window();
            errors = 0;
        endfunction

        function void clear_window();
            foreach (received[i]) begin
                received[i] = 1'b0;
            end
            base      = 0;
            delivered = '0;
        endfunction

        function t_rx_result make_result(input t_kind k, input int seq,
                                         input logic [15:0] size, input logic [31:0] total);
            t_rx_result r;
            r = '0;
            r.kind = k;
            if (k == KIND_ACK) begin
                r.ack_number   = 8'(seq);
                r.ack_checksum = CKSUM_GOOD ^ {8'h00, 8'(seq)};
            end
            if (k == KIND_DELIVER) begin
                r.deliver_seq  = 16'(seq);
                r.deliver_size = size;
            end
            r.total_length = total;
            return r;
        endfunction

        // works out the results one accepted header causes and queues them
        function void note_header(input logic [15:0] w0, w1, w2, w3, w4);
            logic [16:0] acc;
            logic [15:0] words [5];
            logic [32:0] sum33;
            t_rx_result  made [$];
            int          seq;
            int          slot;
            int          steps;
            words = '{w0, w1, w2, w3, w4};
            acc = '0;
            foreach (words[i]) begin
                acc = {1'b0, acc[15:0]} + words[i];
                if (acc[16]) begin
                    acc = {1'b0, acc[15:0]} + 17'd1;
                end
            end
            if (acc[15:0] != CKSUM_GOOD) begin
                return;
            end
            case (w1[7:0])
                TAG_END: begin
                    made.push_back(make_result(KIND_END, 0, '0, '0));
                    clear_window();
                end
                TAG_OVER: begin
                    made.push_back(make_result(KIND_OVER, 0, '0, delivered));
                    clear_window();
                end
                TAG_DATA: begin
                    seq  = int'(w2);
                    slot = seq % SLOTS;
                    if (seq >= base - WINDOW && seq < base + WINDOW) begin
                        made.push_back(make_result(KIND_ACK, seq, '0, '0));
                    end
                    if (seq >= base && seq < base + WINDOW) begin
                        if (!received[slot]) begin
                            received[slot]   = 1'b1;
                            slot_bytes[slot] = w0;
                            if (seq == base) begin
                                steps = 0;
                                while (steps < WINDOW && received[base % SLOTS]) begin
                                    slot = base % SLOTS;
                                    made.push_back(make_result(KIND_DELIVER, base,
                                                               slot_bytes[slot], '0));
                                    sum33 = {1'b0, delivered} + slot_bytes[slot];
                                    delivered = sum33[32] ? 32'hffff_ffff : sum33[31:0];
                                    received[slot] = 1'b0;
                                    base = (base + 1) & 'h1ffff;
                                    steps++;
                                end
                            end
                        end else begin
                            // duplicate inside the window gets a second ack
                            made.push_back(make_result(KIND_ACK, seq, '0, '0));
                        end
                    end
                end
                default: ;
            endcase
            if (made.size() > 0) begin
                made[made.size() - 1].last = 1'b1;
            end
            foreach (made[i]) begin
                pending_results.push_back(made[i]);
            end
        endfunction

        function void check_result(input t_rx_result got);
            t_rx_result want;
            bit         bad;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: kind=%0d ack=%02h ck=%04h seq=%04h",
                             got.kind, got.ack_number, got.ack_checksum, got.deliver_seq);
                end
                return;
            end
            want = pending_results.pop_front();
            bad = (got.kind !== want.kind) || (got.ack_number !== want.ack_number)
                || (got.ack_checksum !== want.ack_checksum)
                || (got.deliver_seq !== want.deliver_seq)
                || (got.deliver_size !== want.deliver_size)
                || (got.total_length !== want.total_length) || (got.last !== want.last);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: kind=%0d ack=%02h ck=%04h seq=%04h size=%04h",
                             want.kind, want.ack_number, want.ack_checksum,
                             want.deliver_seq, want.deliver_size,
                             " total=%08h last=%0b", want.total_length, want.last);
                    $display("         got: kind=%0d ack=%02h ck=%04h seq=%04h size=%04h",
                             got.kind, got.ack_number, got.ack_checksum,
                             got.deliver_seq, got.deliver_size,
                             " total=%08h last=%0b", got.total_length, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_hdr_word0 = '0;
    logic [15:0] i_hdr_word1 = '0;
    logic [15:0] i_hdr_word2 = '0;
    logic [15:0] i_hdr_word3 = '0;
    logic [15:0] i_hdr_word4 = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_ack_number;
    logic [15:0] o_ack_checksum;
    logic [15:0] o_deliver_seq;
    logic [15:0] o_deliver_size;
    logic [31:0] o_total_length;
    logic        o_last;

    window_scoreboard window_sb = new();
    int items_sent   = 0;
    int results_seen = 0;
    int cycle_count  = 0;

    selective_repeat_receiver_window #(
        .WINDOW(WINDOW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_hdr_word0    (i_hdr_word0),
        .i_hdr_word1    (i_hdr_word1),
        .i_hdr_word2    (i_hdr_word2),
        .i_hdr_word3    (i_hdr_word3),
        .i_hdr_word4    (i_hdr_word4),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_ack_number   (o_ack_number),
        .o_ack_checksum (o_ack_checksum),
        .o_deliver_seq  (o_deliver_seq),
        .o_deliver_size (o_deliver_size),
        .o_total_length (o_total_length),
        .o_last         (o_last)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("tb_selective_repeat_receiver_window: done, errors");
            $finish;
        end
    end

    // offers one header item, with a random gap unless in a calm stretch
    task automatic push_header(input logic [15:0] w0, w1, w2, w3, w4);
        int gap;
        gap = (((items_sent / 40) % 4) == 1) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_hdr_word0 <= w0;
        i_hdr_word1 <= w1;
        i_hdr_word2 <= w2;
        i_hdr_word3 <= w3;
        i_hdr_word4 <= w4;
        do @(posedge i_clk); while (!o_in_ready);
        window_sb.note_header(w0, w1, w2, w3, w4);
        items_sent++;
    endtask

    // builds a header with a valid checksum, optionally breaking one bit of it
    task automatic push_good(input logic [7:0] tag, input logic [15:0] seq,
                             input logic [15:0] size, input bit corrupt);
        logic [15:0] w [5];
        logic [16:0] acc;
        int          k;
        w[0] = size;
        w[1] = {8'($urandom), tag};
        w[2] = seq;
        w[3] = 16'($urandom);
        acc = '0;
        for (k = 0; k < 4; k++) begin
            acc = {1'b0, acc[15:0]} + w[k];
            if (acc[16]) begin
                acc = {1'b0, acc[15:0]} + 17'd1;
            end
        end
        w[4] = ~acc[15:0];
        if (corrupt) begin
            k = $urandom_range(0, 4);
            w[k] = w[k] ^ (16'd1 << $urandom_range(0, 15));
        end
        push_header(w[0], w[1], w[2], w[3], w[4]);
    endtask

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // sink side: random stalls, calm stretches and one long hold-off
    initial begin
        t_rx_result got;
        int         gap;
        bit         held;
        held = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            gap = (((results_seen / 60) % 4) == 2) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.kind         = t_kind'(o_kind);
            got.ack_number   = o_ack_number;
            got.ack_checksum = o_ack_checksum;
            got.deliver_seq  = o_deliver_seq;
            got.deliver_size = o_deliver_size;
            got.total_length = o_total_length;
            got.last         = o_last;
            window_sb.check_result(got);
            results_seen++;
        end
    end

    initial begin
        int          offs [WINDOW];
        int          n;
        int          j;
        int          tmp;
        int          pick;
        int          first;
        logic [7:0]  tag;
        logic [15:0] seq;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        push_good(TAG_END, 16'd0, 16'd0, 1'b0);
        push_good(TAG_DATA, 16'd0, 16'hffff, 1'b0);     // at base, slides one slot
        push_good(TAG_DATA, 16'd0, 16'd5, 1'b0);        // below the window, ack only
        push_good(TAG_DATA, 16'd2, 16'd0, 1'b0);        // new, out of order
        push_good(TAG_DATA, 16'd2, 16'd7, 1'b0);        // duplicate
        push_good(TAG_DATA, 16'd1, 16'h1234, 1'b0);     // fills the gap, slides two
        push_good(TAG_DATA, 16'(3 + WINDOW - 1), 16'h00ff, 1'b0);
        push_good(TAG_DATA, 16'(3 + WINDOW), 16'd1, 1'b0);
        push_good(TAG_DATA, 16'hffff, 16'd1, 1'b0);
        push_good(TAG_DATA, 16'hff00, 16'd1, 1'b0);
        push_good(TAG_DATA, 16'd3, 16'd9, 1'b1);        // broken checksum
        push_good(8'h01, 16'd3, 16'd9, 1'b0);
        push_good(8'hff, 16'd3, 16'd9, 1'b0);
        push_header(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        push_good(TAG_DATA, 16'd3, 16'h8000, 1'b0);
        push_good(TAG_OVER, 16'd0, 16'd0, 1'b0);
        push_header(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
        push_header(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_good(TAG_OVER, 16'hffff, 16'hffff, 1'b0);
        push_good(TAG_END, 16'hffff, 16'hffff, 1'b0);

        // random part
        while (items_sent < ITEM_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                // fill a stretch of the window out of order, then close it at the base
                n = ($urandom_range(0, 3) == 0) ? WINDOW : $urandom_range(2, 12);
                first = window_sb.base;
                for (j = 0; j < n - 1; j++) begin
                    offs[j] = j + 1;
                end
                for (j = n - 2; j > 0; j--) begin
                    tmp = $urandom_range(0, j);
                    {offs[j], offs[tmp]} = {offs[tmp], offs[j]};
                end
                for (j = 0; j < n - 1; j++) begin
                    push_good(TAG_DATA, 16'(first + offs[j]), pick_size(), 1'b0);
                    if ($urandom_range(0, 7) == 0) begin
                        push_good(TAG_DATA, 16'(first + offs[j]), pick_size(), 1'b0);
                    end
                end
                push_good(TAG_DATA, 16'(first), pick_size(), 1'b0);
            end else if (pick < 60) begin
                if ($urandom_range(0, 3) != 0) begin
                    seq = 16'(window_sb.base + $urandom_range(0, WINDOW - 1));
                end else begin
                    seq = 16'(window_sb.base + $urandom_range(0, 4 * WINDOW) - 2 * WINDOW);
                end
                push_good(TAG_DATA, seq, pick_size(), 1'b0);
            end else if (pick < 70) begin
                push_good(TAG_DATA, 16'($urandom), pick_size(), 1'b0);
            end else if (pick < 76) begin
                push_good(TAG_DATA, 16'(window_sb.base), pick_size(), 1'b1);
            end else if (pick < 80) begin
                do tag = 8'($urandom);
                while (tag == TAG_DATA || tag == TAG_OVER || tag == TAG_END);
                push_good(tag, 16'(window_sb.base), pick_size(), 1'b0);
            end else if (pick < 83) begin
                push_good(TAG_OVER, 16'($urandom), pick_size(), $urandom_range(0, 5) == 0);
            end else if (pick < 86) begin
                push_good(TAG_END, 16'($urandom), pick_size(), $urandom_range(0, 5) == 0);
            end else begin
                push_header(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
            end
        end
        i_in_valid <= 1'b0;

        while (window_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (window_sb.errors == 0) begin
            $display("tb_selective_repeat_receiver_window: done, clean");
        end else begin
            $display("tb_selective_repeat_receiver_window: done, errors");
        end
        $finish;
    end

endmodule
